// File: hw/rtl/angle_to_hue_wheel_rgb_top_defines.svh
// Assertion macros shared by the hue wheel RTL.
`ifndef ANGLE_TO_HUE_WHEEL_RGB_TOP_DEFINES_SVH
`define ANGLE_TO_HUE_WHEEL_RGB_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define AHW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define AHW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AHW_ASSERT(lbl, clk, rst, prop, msg)
`define AHW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hw/rtl/ahw_pkg.sv
// Types, constants and the arctangent table of the hue wheel block.
package ahw_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int COORD_WIDTH_DEF   = 16;
  localparam int ATAN_TABLE_LEN    = 24;
  localparam int COORD_IN_WIDTH    = 16;
  localparam int ANG_WIDTH         = 32;
  localparam int HUE_WIDTH         = 16;
  localparam int CHAN_WIDTH        = 8;
  localparam int GUARD_BITS        = 3;

  localparam logic [ANG_WIDTH-1:0]  HALF_TURN = 32'h8000_0000;
  localparam logic [CHAN_WIDTH-1:0] CHAN_FULL = 8'hFF;
  localparam logic [CHAN_WIDTH-1:0] CHAN_OFF  = 8'h00;

  typedef struct packed {
    logic signed [COORD_IN_WIDTH-1:0] x_coord;
    logic signed [COORD_IN_WIDTH-1:0] y_coord;
  } req_t;

  typedef struct packed {
    logic [CHAN_WIDTH-1:0] red;
    logic [CHAN_WIDTH-1:0] green;
    logic [CHAN_WIDTH-1:0] blue;
    logic [HUE_WIDTH-1:0]  hue_turn;
  } rsp_t;

  // Six sectors of the hue wheel; codes six and seven never occur.
  typedef enum logic [2:0] {
    SEC_RED_UP    = 3'd0,
    SEC_GREEN_DN  = 3'd1,
    SEC_GREEN_UP  = 3'd2,
    SEC_BLUE_DN   = 3'd3,
    SEC_BLUE_UP   = 3'd4,
    SEC_RED_DN    = 3'd5
  } sector_t;

  // atan(2^-i) as a fraction of a turn, 2^32 per turn.
  function automatic logic [ANG_WIDTH-1:0] atan_turn(input int i);
    logic [ANG_WIDTH-1:0] a;
    case (i)
      0:       a = 32'h2000_0000;
      1:       a = 32'h12E4_051E;
      2:       a = 32'h09FB_385B;
      3:       a = 32'h0511_11D4;
      4:       a = 32'h028B_0D43;
      5:       a = 32'h0145_D7E1;
      6:       a = 32'h00A2_F61E;
      7:       a = 32'h0051_7C55;
      8:       a = 32'h0028_BE53;
      9:       a = 32'h0014_5F2F;
      10:      a = 32'h000A_2F98;
      11:      a = 32'h0005_17CC;
      12:      a = 32'h0002_8BE6;
      13:      a = 32'h0001_45F3;
      14:      a = 32'h0000_A2FA;
      15:      a = 32'h0000_517D;
      16:      a = 32'h0000_28BE;
      17:      a = 32'h0000_145F;
      18:      a = 32'h0000_0A30;
      19:      a = 32'h0000_0518;
      20:      a = 32'h0000_028C;
      21:      a = 32'h0000_0146;
      22:      a = 32'h0000_00A3;
      23:      a = 32'h0000_0051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: hw/rtl/ahw_cell.sv
// One vectoring CORDIC stage: rotate toward the x axis and track the angle.
module ahw_cell #(
  parameter int XW    = 19,
  parameter int STAGE = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            vld_in,
  input  logic signed [XW-1:0]            x_in,
  input  logic signed [XW-1:0]            y_in,
  input  logic [ahw_pkg::ANG_WIDTH-1:0]   ang_in,
  input  logic                            ready_dn,
  output logic                            ready_up,
  output logic                            vld,
  output logic signed [XW-1:0]            x,
  output logic signed [XW-1:0]            y,
  output logic [ahw_pkg::ANG_WIDTH-1:0]   ang
);

  localparam logic [ahw_pkg::ANG_WIDTH-1:0] STEP = ahw_pkg::atan_turn(STAGE);

  logic signed [XW-1:0]          xs, ys, x_next, y_next;
  logic [ahw_pkg::ANG_WIDTH-1:0] ang_next;
  logic                          y_pos, y_neg;

  assign ready_up = !vld || ready_dn;

  always_comb begin
    xs    = x_in >>> STAGE;
    ys    = y_in >>> STAGE;
    y_neg = y_in[XW-1];
    y_pos = !y_in[XW-1] && (|y_in);
    // A zero residual leaves the vector and the angle alone.
    x_next   = x_in;
    y_next   = y_in;
    ang_next = ang_in;
    if (y_pos) begin
      x_next   = x_in + ys;
      y_next   = y_in - xs;
      ang_next = ang_in + STEP;
    end else if (y_neg) begin
      x_next   = x_in - ys;
      y_next   = y_in + xs;
      ang_next = ang_in - STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ready_up) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      x   <= x_next;
      y   <= y_next;
      ang <= ang_next;
    end
  end

endmodule

// File: hw/rtl/ahw_color.sv
// Hue to sector split and HSV wheel color mapping, ending in the output register.
module ahw_color (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          vld_in,
  input  logic [ahw_pkg::ANG_WIDTH-1:0] ang_in,
  output logic                          ready_up,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output ahw_pkg::rsp_t                 rsp
);

  localparam int PW = ahw_pkg::HUE_WIDTH + 3;
  localparam int WW = ahw_pkg::HUE_WIDTH + 1;
  localparam int RW = ahw_pkg::HUE_WIDTH + ahw_pkg::CHAN_WIDTH + 1;
  localparam logic [RW-1:0] HALF_LSB = RW'(1) << (ahw_pkg::HUE_WIDTH - 1);

  logic                            en_b, vld_a;
  logic [PW-1:0]                   p;
  logic [ahw_pkg::HUE_WIDTH-1:0]   hue_in;
  logic [ahw_pkg::HUE_WIDTH-1:0]   hue_a, frac_a;
  ahw_pkg::sector_t                sector_a;
  logic [WW-1:0]                   w;
  logic [RW-1:0]                   ramp_sum;
  logic [ahw_pkg::CHAN_WIDTH-1:0]  ramp;
  ahw_pkg::rsp_t                   rsp_next;

  assign en_b     = !rsp_valid || !rsp_stall;
  assign ready_up = !vld_a || en_b;

  // Hue times six by shift and add.
  always_comb begin
    hue_in = ang_in[ahw_pkg::ANG_WIDTH-1 -: ahw_pkg::HUE_WIDTH];
    p      = (PW'(hue_in) << 2) + (PW'(hue_in) << 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (ready_up) begin
      vld_a <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      hue_a    <= hue_in;
      frac_a   <= p[ahw_pkg::HUE_WIDTH-1:0];
      sector_a <= ahw_pkg::sector_t'(p[PW-1 -: 3]);
    end
  end

  // Ramp level rises in even sectors and falls in odd ones; round w*255.
  always_comb begin
    w        = sector_a[0] ? (WW'(1) << ahw_pkg::HUE_WIDTH) - WW'(frac_a) : WW'(frac_a);
    ramp_sum = (RW'(w) << ahw_pkg::CHAN_WIDTH) - RW'(w) + HALF_LSB;
    ramp     = ramp_sum[ahw_pkg::HUE_WIDTH +: ahw_pkg::CHAN_WIDTH];
    rsp_next.hue_turn = hue_a;
    unique case (sector_a)
      ahw_pkg::SEC_RED_UP: begin
        rsp_next.red   = ahw_pkg::CHAN_FULL;
        rsp_next.green = ramp;
        rsp_next.blue  = ahw_pkg::CHAN_OFF;
      end
      ahw_pkg::SEC_GREEN_DN: begin
        rsp_next.red   = ramp;
        rsp_next.green = ahw_pkg::CHAN_FULL;
        rsp_next.blue  = ahw_pkg::CHAN_OFF;
      end
      ahw_pkg::SEC_GREEN_UP: begin
        rsp_next.red   = ahw_pkg::CHAN_OFF;
        rsp_next.green = ahw_pkg::CHAN_FULL;
        rsp_next.blue  = ramp;
      end
      ahw_pkg::SEC_BLUE_DN: begin
        rsp_next.red   = ahw_pkg::CHAN_OFF;
        rsp_next.green = ramp;
        rsp_next.blue  = ahw_pkg::CHAN_FULL;
      end
      ahw_pkg::SEC_BLUE_UP: begin
        rsp_next.red   = ramp;
        rsp_next.green = ahw_pkg::CHAN_OFF;
        rsp_next.blue  = ahw_pkg::CHAN_FULL;
      end
      default: begin
        rsp_next.red   = ahw_pkg::CHAN_FULL;
        rsp_next.green = ahw_pkg::CHAN_OFF;
        rsp_next.blue  = ramp;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en_b) begin
      rsp_valid <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: hw/rtl/angle_to_hue_wheel_rgb_top.sv
// Top level of the angle to hue wheel color block.
//
// Usage: each request carries one signed point (x_coord, y_coord). The block
// returns the point's angle around the origin as hue_turn (65536 per turn) and
// the fully saturated, full value RGB color of that hue on the HSV wheel.
// The origin maps to pure red.
//
// Channels: req/req_valid/req_stall in, rsp/rsp_valid/rsp_stall out. A request
// moves on an edge with valid high and stall low.
//
// Pipeline: from request to result the data passes one stage that folds the left
// half plane, one cell per CORDIC iteration, one stage that splits the hue into
// sector and fraction, and the output register.
// Throughput: one request per cycle without stall; each pipeline register takes
// new data whenever it is empty or its successor moves, so a stalled result
// holds only the output register; empty stages upstream keep taking requests.
//
// Reset clears all valid bits; the pipeline is empty afterward.
// Stall on the result side backs up the chain stage by stage until req_stall
// rises; no request is dropped.
`include "angle_to_hue_wheel_rgb_top_defines.svh"

module angle_to_hue_wheel_rgb_top #(
  parameter int CORDIC_STAGES = ahw_pkg::CORDIC_STAGES_DEF,
  parameter int COORD_WIDTH   = ahw_pkg::COORD_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  ahw_pkg::req_t req,
  input  logic          req_valid,
  output logic          req_stall,
  output ahw_pkg::rsp_t rsp,
  output logic          rsp_valid,
  input  logic          rsp_stall
);

  // Iterations beyond the arctangent table are not run.
  localparam int NSTG = (CORDIC_STAGES < ahw_pkg::ATAN_TABLE_LEN) ?
                        CORDIC_STAGES : ahw_pkg::ATAN_TABLE_LEN;
  // Headroom for the CORDIC gain and the negation of the most negative value.
  localparam int XW = COORD_WIDTH + ahw_pkg::GUARD_BITS;

  logic [COORD_WIDTH-1:0]        x_raw, y_raw;
  logic signed [XW-1:0]          x_ext, y_ext;
  logic signed [XW-1:0]          px_next, py_next;
  logic [ahw_pkg::ANG_WIDTH-1:0] pang_next;

  // Chain taps: index 0 is the fold stage, index k the output of cell k-1.
  logic signed [XW-1:0]          cx    [NSTG+1];
  logic signed [XW-1:0]          cy    [NSTG+1];
  logic [ahw_pkg::ANG_WIDTH-1:0] cang  [NSTG+1];
  logic [NSTG:0]                 cvld;
  logic [NSTG+1:0]               cready;

  // Take the low COORD_WIDTH bits; a wider setting sees the field zero-filled.
  generate
    if (COORD_WIDTH <= ahw_pkg::COORD_IN_WIDTH) begin : g_narrow
      assign x_raw = req.x_coord[COORD_WIDTH-1:0];
      assign y_raw = req.y_coord[COORD_WIDTH-1:0];
    end else begin : g_wide
      assign x_raw = {{(COORD_WIDTH-ahw_pkg::COORD_IN_WIDTH){1'b0}}, req.x_coord};
      assign y_raw = {{(COORD_WIDTH-ahw_pkg::COORD_IN_WIDTH){1'b0}}, req.y_coord};
    end
  endgenerate

  // Fold the left half plane onto the right one, starting at half a turn.
  always_comb begin
    x_ext = {{ahw_pkg::GUARD_BITS{x_raw[COORD_WIDTH-1]}}, x_raw};
    y_ext = {{ahw_pkg::GUARD_BITS{y_raw[COORD_WIDTH-1]}}, y_raw};
    if (x_ext[XW-1]) begin
      px_next   = -x_ext;
      py_next   = -y_ext;
      pang_next = ahw_pkg::HALF_TURN;
    end else begin
      px_next   = x_ext;
      py_next   = y_ext;
      pang_next = '0;
    end
  end

  // Fold stage register; hold while its successor is full and stalled.
  assign cready[0] = !cvld[0] || cready[1];
  assign req_stall = !cready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cvld[0] <= 1'b0;
    end else if (cready[0]) begin
      cvld[0] <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cready[0]) begin
      cx[0]   <= px_next;
      cy[0]   <= py_next;
      cang[0] <= pang_next;
    end
  end

  // Row of CORDIC cells, one per iteration, each handing off to the next.
  generate
    for (genvar k = 0; k < NSTG; k++) begin : g_cell
      ahw_cell #(
        .XW    (XW),
        .STAGE (k)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .vld_in   (cvld[k]),
        .x_in     (cx[k]),
        .y_in     (cy[k]),
        .ang_in   (cang[k]),
        .ready_dn (cready[k+2]),
        .ready_up (cready[k+1]),
        .vld      (cvld[k+1]),
        .x        (cx[k+1]),
        .y        (cy[k+1]),
        .ang      (cang[k+1])
      );
    end
  endgenerate

  // Map the final angle onto the color wheel and drive the result.
  ahw_color u_color (
    .clk       (clk),
    .rst       (rst),
    .vld_in    (cvld[NSTG]),
    .ang_in    (cang[NSTG]),
    .ready_up  (cready[NSTG+1]),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Empty after reset.
  `AHW_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (!rsp_valid && !cvld[0]), "valid after reset")
  // An accepted request lands in the fold stage.
  `AHW_ASSERT(a_req_lands, clk, rst, (req_valid && !req_stall) |=> cvld[0], "request lost")
  // Every wheel color has one channel full and one channel off.
  `AHW_ASSERT(a_wheel_color, clk, rst,
    rsp_valid |-> ((rsp.red == 8'hFF || rsp.green == 8'hFF || rsp.blue == 8'hFF) &&
                   (rsp.red == 8'h00 || rsp.green == 8'h00 || rsp.blue == 8'h00)),
    "color off the wheel")
  // Hues of the first sector are red with no blue.
  `AHW_ASSERT(a_first_sector, clk, rst,
    (rsp_valid && rsp.hue_turn <= 16'd10922) |-> (rsp.red == 8'hFF && rsp.blue == 8'h00),
    "first sector mismatch")

endmodule
